// File: design/deq_pkg.sv
// deq_pkg: opcodes, chain modes and shared types for the double-ended queue
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package deq_pkg;

	localparam int VALUE_W = 32;
	localparam int OPCODE_W = 3;
	localparam int COUNT_OUT_W = 5;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_OUT_W-1:0] count_out_t;

	localparam opcode_t OP_REPORT = 3'd0;
	localparam opcode_t OP_PUSH_BACK = 3'd1;
	localparam opcode_t OP_PUSH_FRONT = 3'd2;
	localparam opcode_t OP_POP_FRONT = 3'd3;
	localparam opcode_t OP_POP_BACK = 3'd4;

	typedef logic [1:0] chain_mode_t;

	localparam chain_mode_t MODE_HOLD = 2'd0;
	localparam chain_mode_t MODE_SHR = 2'd1;
	localparam chain_mode_t MODE_SHL = 2'd2;
	localparam chain_mode_t MODE_WR = 2'd3;

	localparam value_t EMPTY_VALUE = -32'sd1;

	typedef struct packed {
		logic load;
		logic shift_r;
		logic shift_l;
	} cell_ctrl_t;

endpackage

// File: design/deq_if.sv
// deq_req_if and deq_rsp_if: valid/ready channels of the double-ended queue
// depends on deq_pkg
`timescale 1ns / 1ps

interface deq_req_if
	import deq_pkg::*;
;
	logic valid;
	logic ready;
	opcode_t opcode;
	value_t push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if
	import deq_pkg::*;
;
	logic valid;
	logic ready;
	value_t front_value;
	value_t back_value;
	count_out_t entry_count;
	logic is_empty;
	logic op_error;

	modport source (output valid, output front_value, output back_value,
		output entry_count, output is_empty, output op_error, input ready);
	modport sink (input valid, input front_value, input back_value,
		input entry_count, input is_empty, input op_error, output ready);
endinterface

// File: design/deq_cell.sv
// deq_cell: one storage cell of a value chain; holds, loads or takes a neighbor's value
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_cell
	import deq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  value_t     load_value,
	input  value_t     left_value,
	input  value_t     right_value,
	output value_t     value_q,
	output value_t     value_d
);

	always_comb begin
		priority if (ctrl.load) begin
			value_d = load_value;
		end else if (ctrl.shift_r) begin
			value_d = left_value;
		end else if (ctrl.shift_l) begin
			value_d = right_value;
		end else begin
			value_d = value_q;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

// File: design/deq_chain.sv
// deq_chain: row of DEPTH cells anchored at one end of the queue, cell 0 is the head
// depends on deq_pkg and deq_cell
`timescale 1ns / 1ps

module deq_chain
	import deq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int CW = 5
)(
	input  logic          clk,
	input  chain_mode_t   mode,
	input  logic [CW-1:0] count,
	input  value_t        din,
	output value_t        head_d
);

	value_t     cell_q [DEPTH];
	value_t     cell_d [DEPTH];
	cell_ctrl_t ctrl [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t left_v;
		value_t right_v;

		if (i == 0) begin : g_first
			assign left_v = din;
		end else begin : g_mid_l
			assign left_v = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_q[i];
		end else begin : g_mid_r
			assign right_v = cell_q[i+1];
		end

		assign ctrl[i].load = (mode == MODE_WR) && (count == CW'(i));
		assign ctrl[i].shift_r = (mode == MODE_SHR);
		assign ctrl[i].shift_l = (mode == MODE_SHL);

		deq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl[i]),
			.load_value  (din),
			.left_value  (left_v),
			.right_value (right_v),
			.value_q     (cell_q[i]),
			.value_d     (cell_d[i])
		);
	end

	assign head_d = cell_d[0];

endmodule

// File: design/double_ended_queue.sv
// double_ended_queue: bounded deque of signed 32-bit values, top level
// depends on deq_pkg, deq_if, deq_chain and deq_cell
`timescale 1ns / 1ps

// usage
// req channel carries opcode and push_value: report, push back, push front,
// pop front or pop back. rsp channel returns one item per request: front and
// back values (-1 when empty), entry count, empty flag and error flag.
// a pop on an empty queue or a push on a full one is refused with op_error.
// the values are kept twice, in a front-anchored and a back-anchored chain of
// DEPTH cells; a push loads one chain and shifts the other, a pop shifts
// only the chain anchored at its end. the result is in the output register
// in the cycle after the request is taken. throughput: one item per cycle,
// as long as rsp is taken. req.ready is low only while a result waits and
// rsp.ready is low, so a stalled receiver holds the result and blocks further requests.
// reset clears the count and the output valid; cell contents are left as is
// and are never shown while not holding a stored value.
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input logic       clk,
	input logic       arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          full;
	logic          empty;
	logic          err;
	logic          accept;
	chain_mode_t   front_mode;
	chain_mode_t   back_mode;
	value_t        front_d;
	value_t        back_d;
	logic [CW+COUNT_OUT_W-1:0] count_ext;

	logic       out_valid_q;
	value_t     front_q;
	value_t     back_q;
	count_out_t entry_count_q;
	logic       is_empty_q;
	logic       op_error_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	always_comb begin
		front_mode = MODE_HOLD;
		back_mode = MODE_HOLD;
		count_d = count_q;
		err = 1'b0;
		if (accept) begin
			unique case (req.opcode)
				OP_PUSH_BACK: begin
					if (full) begin
						err = 1'b1;
					end else begin
						front_mode = MODE_WR;
						back_mode = MODE_SHR;
						count_d = count_q + CW'(1);
					end
				end
				OP_PUSH_FRONT: begin
					if (full) begin
						err = 1'b1;
					end else begin
						front_mode = MODE_SHR;
						back_mode = MODE_WR;
						count_d = count_q + CW'(1);
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						front_mode = MODE_SHL;
						count_d = count_q - CW'(1);
					end
				end
				OP_POP_BACK: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						back_mode = MODE_SHL;
						count_d = count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	deq_chain #(.DEPTH(DEPTH), .CW(CW)) u_front (
		.clk    (clk),
		.mode   (front_mode),
		.count  (count_q),
		.din    (req.push_value),
		.head_d (front_d)
	);

	deq_chain #(.DEPTH(DEPTH), .CW(CW)) u_back (
		.clk    (clk),
		.mode   (back_mode),
		.count  (count_q),
		.din    (req.push_value),
		.head_d (back_d)
	);

	assign count_ext = (CW + COUNT_OUT_W)'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q <= (count_d == '0) ? EMPTY_VALUE : front_d;
			back_q <= (count_d == '0) ? EMPTY_VALUE : back_d;
			entry_count_q <= count_ext[COUNT_OUT_W-1:0];
			is_empty_q <= (count_d == '0);
			op_error_q <= err;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.front_value = front_q;
	assign rsp.back_value = back_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_empty = is_empty_q;
	assign rsp.op_error = op_error_q;

endmodule
